### hdl/bicubic_bezier_patch_eval_macros.svh
// Assertion macros for the bicubic patch evaluator, used by bbpe_combine.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_MACROS_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBPE_ASSERT_SAME(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBPE_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

### hdl/bbpe_pkg.sv
// Types, widths and constants shared by the bicubic patch evaluator.
`timescale 1ns / 1ps
package bbpe_pkg;
   localparam int COORD_W         = 32;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
   localparam int WGT_W           = PARAM_W + 1;
   localparam int SUBDIV_W        = 8;
   localparam int IDX_W           = 8;
   localparam int DIV_STEPS       = 4;
   localparam int DIV_STAGES      = PARAM_FRAC_BITS / DIV_STEPS;
   localparam int GRID_N          = 4;
   localparam int ADDR_W          = 4;
   localparam int GRID_DEPTH      = GRID_N * GRID_N;

   localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = SUBDIV_W'(7);
   localparam logic [PARAM_W-1:0]  PARAM_ONE    = PARAM_W'(1) << PARAM_FRAC_BITS;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_EVAL  = 1'b1
   } bbpe_func_type;

   typedef struct packed {
      bbpe_func_type      func;
      logic [1:0]         anchor_row;
      logic [1:0]         anchor_col;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [7:0]         grid_row;
      logic [7:0]         grid_col;
   } bbpe_req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [16:0]        tex_s;
      logic [16:0]        tex_t;
   } bbpe_rsp_type;

   // Request fields that travel down the pipeline next to the parameters.
   typedef struct packed {
      bbpe_func_type             func;
      logic [ADDR_W-1:0]         addr;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } bbpe_tag_type;

   typedef logic [GRID_N-1:0][WGT_W-1:0] bbpe_wgt_type;
endpackage

### hdl/bbpe_param.sv
// Clamp of the grid indices and pipelined division forming s and t.
`timescale 1ns / 1ps
module bbpe_param (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  bbpe_pkg::bbpe_req_type           in_req,
   input  logic [bbpe_pkg::SUBDIV_W-1:0]    subdiv,
   output logic                             out_valid,
   output bbpe_pkg::bbpe_tag_type           out_tag,
   output logic [bbpe_pkg::PARAM_W-1:0]     out_s,
   output logic [bbpe_pkg::PARAM_W-1:0]     out_t
);
   import bbpe_pkg::*;

   logic [SUBDIV_W-1:0] divisor;
   logic                valid_ff [DIV_STAGES+1];
   logic                valid_in [DIV_STAGES+1];
   bbpe_tag_type        tag_ff   [DIV_STAGES+1];
   bbpe_tag_type        tag_in   [DIV_STAGES+1];
   logic [SUBDIV_W-1:0] rem_ff   [DIV_STAGES+1][2];
   logic [SUBDIV_W-1:0] rem_in   [DIV_STAGES+1][2];
   logic [PARAM_W-1:0]  quo_ff   [DIV_STAGES+1][2];
   logic [PARAM_W-1:0]  quo_in   [DIV_STAGES+1][2];

   // A zero step count behaves as one.
   assign divisor = (subdiv == '0) ? SUBDIV_W'(1) : subdiv;

   // First stage clamps the index and settles the integer quotient bit.
   // Later stages run DIV_STEPS restoring division steps each on the fraction bits.
   always_comb begin
      logic [IDX_W-1:0]    idx [2];
      logic [IDX_W-1:0]    clamped;
      logic [SUBDIV_W-1:0] r;
      logic [SUBDIV_W:0]   trial;
      logic [PARAM_W-1:0]  q;
      idx[0] = in_req.grid_row;
      idx[1] = in_req.grid_col;
      valid_in[0]  = in_valid;
      tag_in[0].func = in_req.func;
      tag_in[0].addr = {in_req.anchor_row, in_req.anchor_col};
      tag_in[0].x    = in_req.coord_x;
      tag_in[0].y    = in_req.coord_y;
      tag_in[0].z    = in_req.coord_z;
      for (int a = 0; a < 2; a++) begin
         clamped = (idx[a] > divisor) ? divisor : idx[a];
         if (clamped == divisor) begin
            quo_in[0][a] = PARAM_W'(1);
            rem_in[0][a] = '0;
         end else begin
            quo_in[0][a] = '0;
            rem_in[0][a] = clamped;
         end
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
         tag_in[k]   = tag_ff[k-1];
         for (int a = 0; a < 2; a++) begin
            r = rem_ff[k-1][a];
            q = quo_ff[k-1][a];
            for (int st = 0; st < DIV_STEPS; st++) begin
               trial = {r, 1'b0};
               if (trial >= {1'b0, divisor}) begin
                  trial = trial - {1'b0, divisor};
                  q = {q[PARAM_W-2:0], 1'b1};
               end else begin
                  q = {q[PARAM_W-2:0], 1'b0};
               end
               r = trial[SUBDIV_W-1:0];
            end
            rem_in[k][a] = r;
            quo_in[k][a] = q;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) valid_ff[k] <= 1'b0;
      end else if (enable) begin
         for (int k = 0; k <= DIV_STAGES; k++) valid_ff[k] <= valid_in[k];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            tag_ff[k] <= tag_in[k];
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES];
   assign out_tag   = tag_ff[DIV_STAGES];
   assign out_s     = quo_ff[DIV_STAGES][0];
   assign out_t     = quo_ff[DIV_STAGES][1];
endmodule

### hdl/bbpe_weights.sv
// Cubic Bernstein weights of s and t over three multiply stages.
`timescale 1ns / 1ps
module bbpe_weights (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  bbpe_pkg::bbpe_tag_type       in_tag,
   input  logic [bbpe_pkg::PARAM_W-1:0] in_s,
   input  logic [bbpe_pkg::PARAM_W-1:0] in_t,
   output logic                         out_valid,
   output bbpe_pkg::bbpe_tag_type       out_tag,
   output bbpe_pkg::bbpe_wgt_type       out_ws,
   output bbpe_pkg::bbpe_wgt_type       out_wt,
   output logic [bbpe_pkg::PARAM_W-1:0] out_s,
   output logic [bbpe_pkg::PARAM_W-1:0] out_t
);
   import bbpe_pkg::*;

   localparam int NSTG = 3;

   logic               valid_ff [NSTG];
   bbpe_tag_type       tag_ff   [NSTG];
   logic [PARAM_W-1:0] tex_ff   [NSTG][2];
   logic [PARAM_W-1:0] u_ff  [2], u_in  [2];
   logic [PARAM_W-1:0] v_ff  [2], v_in  [2];
   logic [PARAM_W-1:0] uu_ff [2], uu_in [2];
   logic [PARAM_W-1:0] vv_ff [2], vv_in [2];
   logic [PARAM_W-1:0] p_ff  [2][GRID_N], p_in [2][GRID_N];
   bbpe_wgt_type       w_ff  [2], w_in  [2];

   // Truncated product of two unsigned Q1.16 fractions.
   function automatic logic [PARAM_W-1:0] frac_mul(input logic [PARAM_W-1:0] a,
                                                    input logic [PARAM_W-1:0] b);
      logic [2*PARAM_W-1:0] full;
      full = a * b;
      return full[PARAM_FRAC_BITS +: PARAM_W];
   endfunction

   // Stage one: squares of u and of one minus u.
   always_comb begin
      logic [PARAM_W-1:0] u [2];
      logic [PARAM_W-1:0] v;
      u[0] = in_s;
      u[1] = in_t;
      for (int a = 0; a < 2; a++) begin
         v        = PARAM_ONE - u[a];
         u_in[a]  = u[a];
         v_in[a]  = v;
         uu_in[a] = frac_mul(u[a], u[a]);
         vv_in[a] = frac_mul(v, v);
      end
   end

   // Stage two: the cubic products.
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         p_in[a][0] = frac_mul(uu_ff[a], u_ff[a]);
         p_in[a][1] = frac_mul(uu_ff[a], v_ff[a]);
         p_in[a][2] = frac_mul(u_ff[a], vv_ff[a]);
         p_in[a][3] = frac_mul(vv_ff[a], v_ff[a]);
      end
   end

   // Stage three: the factor three on the middle weights.
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         w_in[a][0] = WGT_W'(p_ff[a][0]);
         w_in[a][1] = WGT_W'(p_ff[a][1]) + (WGT_W'(p_ff[a][1]) << 1);
         w_in[a][2] = WGT_W'(p_ff[a][2]) + (WGT_W'(p_ff[a][2]) << 1);
         w_in[a][3] = WGT_W'(p_ff[a][3]);
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) valid_ff[k] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NSTG; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (enable) begin
         tag_ff[0]    <= in_tag;
         tex_ff[0][0] <= in_s;
         tex_ff[0][1] <= in_t;
         for (int k = 1; k < NSTG; k++) begin
            tag_ff[k] <= tag_ff[k-1];
            tex_ff[k] <= tex_ff[k-1];
         end
         u_ff  <= u_in;
         v_ff  <= v_in;
         uu_ff <= uu_in;
         vv_ff <= vv_in;
         p_ff  <= p_in;
         w_ff  <= w_in;
      end
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_tag   = tag_ff[NSTG-1];
   assign out_ws    = w_ff[0];
   assign out_wt    = w_ff[1];
   assign out_s     = tex_ff[NSTG-1][0];
   assign out_t     = tex_ff[NSTG-1][1];
endmodule

### hdl/bbpe_combine.sv
// Control grid storage, weighted sums and the saturated output register.
`timescale 1ns / 1ps
module bbpe_combine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  bbpe_pkg::bbpe_tag_type       in_tag,
   input  bbpe_pkg::bbpe_wgt_type       in_ws,
   input  bbpe_pkg::bbpe_wgt_type       in_wt,
   input  logic [bbpe_pkg::PARAM_W-1:0] in_s,
   input  logic [bbpe_pkg::PARAM_W-1:0] in_t,
   output logic                         rsp_valid,
   output bbpe_pkg::bbpe_rsp_type       rsp
);
   import bbpe_pkg::*;
   `include "bicubic_bezier_patch_eval_macros.svh"

   localparam int PROD_W      = WGT_W + 1 + COORD_W;
   localparam int INNER_SUM_W = PROD_W + 2;
   localparam int INNER_W     = INNER_SUM_W - PARAM_FRAC_BITS;
   localparam int OPROD_W     = WGT_W + 1 + INNER_W;
   localparam int ACC_W       = OPROD_W + 2;
   localparam int NSTG        = 4;

   logic signed [COORD_W-1:0] grid_ff [3][GRID_DEPTH];
   logic signed [PROD_W-1:0]  prod_ff  [3][GRID_DEPTH];
   logic signed [PROD_W-1:0]  prod_in  [3][GRID_DEPTH];
   logic signed [INNER_W-1:0] inner_ff [3][GRID_N];
   logic signed [INNER_W-1:0] inner_in [3][GRID_N];
   logic signed [OPROD_W-1:0] oprod_ff [3][GRID_N];
   logic signed [OPROD_W-1:0] oprod_in [3][GRID_N];
   logic signed [ACC_W-1:0]   acc_ff   [3];
   logic signed [ACC_W-1:0]   acc_in   [3];
   logic                      valid_ff [NSTG];
   logic [PARAM_W-1:0]        tex_ff   [NSTG][2];
   bbpe_wgt_type              wt1_ff, wt2_ff;
   logic                      rsp_valid_ff;
   bbpe_rsp_type              rsp_ff, rsp_in;
   logic signed [COORD_W-1:0] sat_val [3];
   logic                      write_en;

   // Control point writes land in the stage where evaluations read the grid.
   assign write_en = enable && in_valid && (in_tag.func == FUNC_WRITE);

   always_ff @(posedge clock) begin
      if (write_en) begin
         grid_ff[0][in_tag.addr] <= in_tag.x;
         grid_ff[1][in_tag.addr] <= in_tag.y;
         grid_ff[2][in_tag.addr] <= in_tag.z;
      end
   end

   // Stage one: s weight times every control point.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < GRID_N; i++) begin
            for (int j = 0; j < GRID_N; j++) begin
               prod_in[a][i*GRID_N+j] = $signed({1'b0, in_ws[j]}) * grid_ff[a][i*GRID_N+j];
            end
         end
      end
   end

   // Stage two: inner sums over one row, floored back to coordinate format.
   always_comb begin
      logic signed [INNER_SUM_W-1:0] sum;
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < GRID_N; i++) begin
            sum = '0;
            for (int j = 0; j < GRID_N; j++) begin
               sum = sum + INNER_SUM_W'(prod_ff[a][i*GRID_N+j]);
            end
            sum = sum >>> PARAM_FRAC_BITS;
            inner_in[a][i] = sum[INNER_W-1:0];
         end
      end
   end

   // Stage three: t weight times each row sum.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < GRID_N; i++) begin
            oprod_in[a][i] = $signed({1'b0, wt2_ff[i]}) * inner_ff[a][i];
         end
      end
   end

   // Stage four: outer sum.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         acc_in[a] = '0;
         for (int i = 0; i < GRID_N; i++) begin
            acc_in[a] = acc_in[a] + ACC_W'(oprod_ff[a][i]);
         end
      end
   end

   // Output stage: floor to coordinate format and saturate.
   always_comb begin
      logic signed [ACC_W-1:0] sh;
      for (int a = 0; a < 3; a++) begin
         sh = acc_ff[a] >>> PARAM_FRAC_BITS;
         if ((&sh[ACC_W-1:COORD_W-1]) || !(|sh[ACC_W-1:COORD_W-1])) begin
            sat_val[a] = sh[COORD_W-1:0];
         end else if (sh[ACC_W-1]) begin
            sat_val[a] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            sat_val[a] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
      rsp_in.point_x = sat_val[0];
      rsp_in.point_y = sat_val[1];
      rsp_in.point_z = sat_val[2];
      rsp_in.tex_s   = tex_ff[NSTG-1][0];
      rsp_in.tex_t   = tex_ff[NSTG-1][1];
   end

   // Valid bits; only evaluate requests make a response.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) valid_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid && (in_tag.func == FUNC_EVAL);
         for (int k = 1; k < NSTG; k++) valid_ff[k] <= valid_ff[k-1];
         rsp_valid_ff <= valid_ff[NSTG-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff      <= prod_in;
         inner_ff     <= inner_in;
         oprod_ff     <= oprod_in;
         acc_ff       <= acc_in;
         wt1_ff       <= in_wt;
         wt2_ff       <= wt1_ff;
         tex_ff[0][0] <= in_s;
         tex_ff[0][1] <= in_t;
         for (int k = 1; k < NSTG; k++) tex_ff[k] <= tex_ff[k-1];
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `BBPE_ASSERT_NEXT(a_write_no_rsp, clock, reset, write_en, !valid_ff[0], "write request entered the sum pipeline")
   `BBPE_ASSERT_SAME(a_tex_range, clock, reset, rsp_valid_ff, rsp_ff.tex_s <= PARAM_ONE && rsp_ff.tex_t <= PARAM_ONE, "texture coordinate above one")
   `BBPE_ASSERT_NEXT(a_stall_hold, clock, reset, !enable, $stable(valid_ff[NSTG-1]) && $stable(acc_ff[0]), "pipeline moved while stalled")
endmodule

### hdl/bicubic_bezier_patch_eval.sv
// Top level of the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps
// Each request either loads one control point of the 4x4 grid or evaluates
// the patch at grid step (grid_row, grid_col) divided by the step count held
// in the csr register (reset value 7, zero acts as one). The block takes one
// request every cycle while req_stall is low; an evaluation passes through
// five stages of the parameter divider, three of the weight products and five
// of the weighted sums and output register. A write makes no response and
// takes effect in order with the evaluations around it. When the response is
// stalled, the whole pipeline holds and req_stall is raised. Reading a
// control point that was never loaded gives an unspecified value.
module bicubic_bezier_patch_eval (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bbpe_pkg::SUBDIV_W-1:0]     csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bbpe_pkg::bbpe_req_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bbpe_pkg::bbpe_rsp_type            rsp_payload
);
   import bbpe_pkg::*;

   logic [SUBDIV_W-1:0] subdiv_val_ff;
   logic                enable;
   logic                p_valid, w_valid;
   bbpe_tag_type        p_tag, w_tag;
   logic [PARAM_W-1:0]  p_s, p_t, w_s, w_t;
   bbpe_wgt_type        w_ws, w_wt;

   // Step count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         subdiv_val_ff <= SUBDIV_RESET;
      end else if (csr_write) begin
         subdiv_val_ff <= csr_wdata;
      end
   end

   // The pipeline advances unless a finished response is being held back.
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   bbpe_param u_param (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_req    (req_payload),
      .subdiv    (subdiv_val_ff),
      .out_valid (p_valid),
      .out_tag   (p_tag),
      .out_s     (p_s),
      .out_t     (p_t)
   );

   bbpe_weights u_weights (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p_valid),
      .in_tag    (p_tag),
      .in_s      (p_s),
      .in_t      (p_t),
      .out_valid (w_valid),
      .out_tag   (w_tag),
      .out_ws    (w_ws),
      .out_wt    (w_wt),
      .out_s     (w_s),
      .out_t     (w_t)
   );

   bbpe_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (w_valid),
      .in_tag    (w_tag),
      .in_ws     (w_ws),
      .in_wt     (w_wt),
      .in_s      (w_s),
      .in_t      (w_t),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );
endmodule
